// ===== rtl/tpf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpf_pkg: trace packet framer shared definitions
// Payload types, packet kind codes, framing phases and decode result structs.
// ----------------------------------------------------------------------------
package tpf_pkg;

    localparam int DEFAULT_MAX_CYC_BYTES = 16;
    localparam int PKT_LEN_W             = 5;
    localparam int BYTES_LEFT_W          = 4;

    // escape byte that opens a two-byte header
    localparam logic [7:0] HDR_ESC = 8'h02;

    typedef enum logic [4:0] {
        K_INCOMPLETE = 5'd0,
        K_ERROR      = 5'd1,
        K_PAD        = 5'd2,
        K_TNT_SHORT  = 5'd3,
        K_VMCS       = 5'd4,
        K_PSB        = 5'd5,
        K_CBR        = 5'd6,
        K_TRACESTOP  = 5'd7,
        K_PIP        = 5'd8,
        K_MNT        = 5'd9,
        K_PSBEND     = 5'd10,
        K_TNT_LONG   = 5'd11,
        K_TMA        = 5'd12,
        K_OVF        = 5'd13,
        K_TIP_PGD    = 5'd14,
        K_TIP_PGE    = 5'd15,
        K_TSC        = 5'd16,
        K_MODE       = 5'd17,
        K_MTC        = 5'd18,
        K_TIP        = 5'd19,
        K_FUP        = 5'd20,
        K_CYC        = 5'd21
    } kind_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_ESCAPE = 2'd1,
        PH_SKIP   = 2'd2,
        PH_CYC    = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } byte_item_t;

    typedef struct packed {
        logic [4:0] packet_kind;
        logic [4:0] packet_length;
    } pkt_item_t;

    typedef struct packed {
        kind_t                  kind;
        logic [PKT_LEN_W-1:0]   len;
    } class_t;

    typedef struct packed {
        logic      has_result;
        pkt_item_t item;
    } step_t;

endpackage : tpf_pkg
`default_nettype wire

// ===== rtl/trace_packet_framer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// path: a byte is held in the input register, framed, and its result is
// registered in the result register, from which it transfers; bytes that end no
// packet give no result
// throughput: one byte per cycle while pkt_stall does not hold the result
// register, set by the combinational framing step between the input register and the result register
// reset: rst_n clears both register valids and the framing state, so the
// first byte after reset is taken as a packet header
// ----------------------------------------------------------------------------
// trace_packet_framer_top: processor trace packet framer
// Frames a trace byte stream and reports each packet's kind and length.
// ----------------------------------------------------------------------------
module trace_packet_framer_top #(
    parameter int MAX_CYC_BYTES = tpf_pkg::DEFAULT_MAX_CYC_BYTES
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_valid,
    output logic                     byte_stall,
    input  wire tpf_pkg::byte_item_t byte_item,
    output logic                     pkt_valid,
    input  wire logic                pkt_stall,
    output tpf_pkg::pkt_item_t       pkt_item
);
    import tpf_pkg::*;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    byte_item_t s1_item_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    pkt_item_t  out_item_reg;

    logic       out_free;
    logic       s1_fire;
    logic       byte_xfer;
    step_t      step;

    assign out_free   = !out_valid_reg || !pkt_stall;
    assign s1_fire    = s1_valid_reg && out_free;
    assign byte_stall = s1_valid_reg && !s1_fire;
    assign byte_xfer  = byte_valid && !byte_stall;

    tpf_framer #(
        .MAX_CYC_BYTES (MAX_CYC_BYTES)
    ) u_framer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (s1_fire),
        .item    (s1_item_reg),
        .result  (step)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (byte_xfer)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_fire && step.has_result)
            out_valid_next = 1'b1;
        else if (!pkt_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_xfer)
            s1_item_reg <= byte_item;
        if (s1_fire && step.has_result)
            out_item_reg <= step.item;
    end

    assign pkt_valid = out_valid_reg;
    assign pkt_item  = out_item_reg;

    // a framed result always lands in the result register
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && step.has_result) |=> (pkt_valid && pkt_item == $past(step.item)))
        else $error("framed result not registered");

    // error and incomplete transfers carry no length
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (pkt_valid && (pkt_item.packet_kind == K_ERROR
                       || pkt_item.packet_kind == K_INCOMPLETE))
        |-> (pkt_item.packet_length == '0))
        else $error("error or incomplete result with nonzero length");

    // no packet is longer than a psb
    a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid |-> (pkt_item.packet_length <= 5'd16))
        else $error("packet length out of range");

    // the input stage never holds a byte while the result side can take it
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_valid_reg) |-> !byte_stall)
        else $error("input stalled with result register empty");

endmodule : trace_packet_framer_top
`default_nettype wire

// ===== rtl/tpf_classify.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpf_classify: packet header decoder
// Maps a header byte, or the byte after an escape, to a packet kind and length.
// ----------------------------------------------------------------------------
module tpf_classify (
    input  wire logic [7:0]     hdr_byte,
    input  wire logic           is_escape,
    output tpf_pkg::class_t     cls
);
    import tpf_pkg::*;

    localparam logic [7:0] HDR_TSC  = 8'h19;
    localparam logic [7:0] HDR_MODE = 8'h99;
    localparam logic [7:0] HDR_MTC  = 8'h59;

    localparam logic [7:0] EXT_VMCS      = 8'hc8;
    localparam logic [7:0] EXT_PSB       = 8'h82;
    localparam logic [7:0] EXT_CBR       = 8'h03;
    localparam logic [7:0] EXT_TRACESTOP = 8'h83;
    localparam logic [7:0] EXT_PIP       = 8'h43;
    localparam logic [7:0] EXT_MNT       = 8'hc3;
    localparam logic [7:0] EXT_PSBEND    = 8'h23;
    localparam logic [7:0] EXT_TNT_LONG  = 8'ha3;
    localparam logic [7:0] EXT_TMA       = 8'h73;
    localparam logic [7:0] EXT_OVF       = 8'hf3;

    // ip packet length by top three header bits
    localparam logic [PKT_LEN_W-1:0] IP_LEN [8] = '{
        5'd1, 5'd3, 5'd5, 5'd7, 5'd7, 5'd1, 5'd9, 5'd1
    };

    logic [PKT_LEN_W-1:0] ip_len;
    class_t               hdr_cls;
    class_t               esc_cls;

    assign ip_len = IP_LEN[hdr_byte[7:5]];

    always_comb
    begin
        hdr_cls.kind = K_ERROR;
        hdr_cls.len  = '0;
        if (!hdr_byte[0])
        begin
            hdr_cls.len  = 5'd1;
            hdr_cls.kind = (hdr_byte == 8'h00) ? K_PAD : K_TNT_SHORT;
        end
        else if (hdr_byte[1:0] == 2'b11)
        begin
            hdr_cls.len  = 5'd1;
            hdr_cls.kind = K_CYC;
        end
        else if (hdr_byte[2:0] == 3'b001)
        begin
            if (!hdr_byte[3])
            begin
                hdr_cls.len  = ip_len;
                hdr_cls.kind = hdr_byte[4] ? K_TIP_PGE : K_TIP_PGD;
            end
            else if (hdr_byte == HDR_TSC)
            begin
                hdr_cls.len  = 5'd8;
                hdr_cls.kind = K_TSC;
            end
            else if (hdr_byte == HDR_MODE)
            begin
                hdr_cls.len  = 5'd2;
                hdr_cls.kind = K_MODE;
            end
            else if (hdr_byte == HDR_MTC)
            begin
                hdr_cls.len  = 5'd2;
                hdr_cls.kind = K_MTC;
            end
        end
        else if (hdr_byte[3])
        begin
            // bits 2..0 are 101
            hdr_cls.len  = ip_len;
            hdr_cls.kind = hdr_byte[4] ? K_FUP : K_TIP;
        end
    end

    always_comb
    begin
        esc_cls.kind = K_ERROR;
        esc_cls.len  = '0;
        case (hdr_byte)
            EXT_VMCS:
            begin
                esc_cls.kind = K_VMCS;
                esc_cls.len  = 5'd7;
            end
            EXT_PSB:
            begin
                esc_cls.kind = K_PSB;
                esc_cls.len  = 5'd16;
            end
            EXT_CBR:
            begin
                esc_cls.kind = K_CBR;
                esc_cls.len  = 5'd4;
            end
            EXT_TRACESTOP:
            begin
                esc_cls.kind = K_TRACESTOP;
                esc_cls.len  = 5'd2;
            end
            EXT_PIP:
            begin
                esc_cls.kind = K_PIP;
                esc_cls.len  = 5'd8;
            end
            EXT_MNT:
            begin
                esc_cls.kind = K_MNT;
                esc_cls.len  = 5'd11;
            end
            EXT_PSBEND:
            begin
                esc_cls.kind = K_PSBEND;
                esc_cls.len  = 5'd2;
            end
            EXT_TNT_LONG:
            begin
                esc_cls.kind = K_TNT_LONG;
                esc_cls.len  = 5'd8;
            end
            EXT_TMA:
            begin
                esc_cls.kind = K_TMA;
                esc_cls.len  = 5'd7;
            end
            EXT_OVF:
            begin
                esc_cls.kind = K_OVF;
                esc_cls.len  = 5'd2;
            end
            default:
            begin
                esc_cls.kind = K_ERROR;
                esc_cls.len  = '0;
            end
        endcase
    end

    assign cls = is_escape ? esc_cls : hdr_cls;

endmodule : tpf_classify
`default_nettype wire

// ===== rtl/tpf_framer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpf_framer: packet framing state and per-byte step
// Holds phase, skip count and cyc byte count; decides each byte's result.
// ----------------------------------------------------------------------------
module tpf_framer #(
    parameter int MAX_CYC_BYTES = tpf_pkg::DEFAULT_MAX_CYC_BYTES
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step_en,
    input  wire tpf_pkg::byte_item_t item,
    output tpf_pkg::step_t           result
);
    import tpf_pkg::*;

    localparam int CW = $clog2(MAX_CYC_BYTES + 1);
    localparam logic [PKT_LEN_W-1:0] USED_HDR = 5'd1;
    localparam logic [PKT_LEN_W-1:0] USED_ESC = 5'd2;

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic [BYTES_LEFT_W-1:0] bytes_left_reg;
    logic [BYTES_LEFT_W-1:0] bytes_left_next;
    logic [CW-1:0]           cyc_seen_reg;
    logic [CW-1:0]           cyc_seen_next;

    class_t                  cls;
    logic [CW-1:0]           cyc_inc;
    logic                    do_skip;
    logic [PKT_LEN_W-1:0]    skip_len;
    logic [PKT_LEN_W-1:0]    skip_used;
    logic [PKT_LEN_W-1:0]    skip_rem;
    logic                    last;

    assign last     = item.end_of_stream;
    assign cyc_inc  = cyc_seen_reg + CW'(1);
    assign skip_rem = skip_len - skip_used;

    tpf_classify u_classify (
        .hdr_byte  (item.data_byte),
        .is_escape (phase_reg == PH_ESCAPE),
        .cls       (cls)
    );

    always_comb
    begin
        phase_next         = phase_reg;
        bytes_left_next    = bytes_left_reg;
        cyc_seen_next      = cyc_seen_reg;
        result.has_result  = 1'b0;
        result.item.packet_kind   = K_INCOMPLETE;
        result.item.packet_length = '0;
        do_skip   = 1'b0;
        skip_len  = cls.len;
        skip_used = USED_HDR;

        case (phase_reg)
            PH_HEADER:
            begin
                if (item.data_byte == HDR_ESC)
                begin
                    if (last)
                        result.has_result = 1'b1;
                    else
                        phase_next = PH_ESCAPE;
                end
                else if (item.data_byte[2:0] == 3'b111)
                begin
                    // extended cyc: count bytes until bit 0 clears
                    if (last)
                        result.has_result = 1'b1;
                    else
                    begin
                        cyc_seen_next = CW'(1);
                        phase_next    = PH_CYC;
                    end
                end
                else
                begin
                    result.has_result         = 1'b1;
                    result.item.packet_kind   = cls.kind;
                    result.item.packet_length = cls.len;
                    do_skip   = 1'b1;
                    skip_used = USED_HDR;
                end
            end
            PH_ESCAPE:
            begin
                result.has_result         = 1'b1;
                result.item.packet_kind   = cls.kind;
                result.item.packet_length = cls.len;
                do_skip   = 1'b1;
                skip_used = USED_ESC;
            end
            PH_SKIP:
            begin
                if (bytes_left_reg != '0)
                    bytes_left_next = bytes_left_reg - BYTES_LEFT_W'(1);
                if (bytes_left_next == '0)
                    phase_next = PH_HEADER;
            end
            PH_CYC:
            begin
                cyc_seen_next = cyc_inc;
                if (!item.data_byte[0])
                begin
                    result.has_result         = 1'b1;
                    result.item.packet_kind   = K_CYC;
                    result.item.packet_length = PKT_LEN_W'(cyc_inc);
                    phase_next = PH_HEADER;
                end
                else if (cyc_inc >= CW'(MAX_CYC_BYTES))
                begin
                    result.has_result       = 1'b1;
                    result.item.packet_kind = K_ERROR;
                    phase_next = PH_HEADER;
                end
                else if (last)
                    result.has_result = 1'b1;
            end
            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase

        // error lengths come back as zero, so they fall through to header
        if (do_skip)
        begin
            if (skip_len > skip_used)
            begin
                bytes_left_next = skip_rem[BYTES_LEFT_W-1:0];
                phase_next      = (bytes_left_next != '0) ? PH_SKIP : PH_HEADER;
            end
            else
            begin
                bytes_left_next = '0;
                phase_next      = PH_HEADER;
            end
        end

        if (phase_next != PH_CYC)
            cyc_seen_next = '0;

        if (last)
        begin
            phase_next      = PH_HEADER;
            bytes_left_next = '0;
            cyc_seen_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            bytes_left_reg <= '0;
            cyc_seen_reg   <= '0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            cyc_seen_reg   <= cyc_seen_next;
        end
    end

endmodule : tpf_framer
`default_nettype wire
